### rtl/ups_pkg.sv
// shared constants, codes and controller/datapath interface types for the path splitter
package ups_pkg;

    localparam int HOST_MAX = 32;
    localparam int HOST_AW  = (HOST_MAX > 1) ? $clog2(HOST_MAX) : 1;
    localparam int HOST_CW  = $clog2(HOST_MAX + 1);
    localparam int CHAR_W   = 16;

    localparam logic [CHAR_W-1:0] CH_AT    = 16'h0040;
    localparam logic [CHAR_W-1:0] CH_BSL   = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_SLASH = 16'h002F;

    typedef enum logic [2:0] {
        PH_START,
        PH_LEAD,
        PH_HOST,
        PH_SHARE,
        PH_FILE,
        PH_SINK
    } phase_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_PFX2,
        CS_PFX_RD,
        CS_TAIL,
        CS_END
    } ctl_state_t;

    typedef enum logic [1:0] {
        PART_HOST,
        PART_SHARE,
        PART_FILE,
        PART_END
    } part_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_NO_LEAD,
        STAT_NO_SHARE,
        STAT_HOST_LONG
    } stat_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_CH,
        SRC_BSL,
        SRC_RAM
    } src_t;

    typedef struct packed {
        logic  emit;
        part_t part;
        src_t  src;
        stat_t status;
        logic  run_end;
        logic  host_wr;
        logic  set_err;
        stat_t err_code;
        logic  set_fls;
        logic  clr_fls;
        logic  rd_clr;
        logic  rd_inc;
        logic  clr_all;
    } cmd_t;

    typedef struct packed {
        logic  out_free;
        logic  is_sep;
        logic  host_full;
        logic  pfx_done;
        logic  fls;
        stat_t err;
    } sts_t;

endpackage

### rtl/unc_path_splitter.sv
// Network path splitter: takes one 16-bit character per transfer and returns host, share and
// file characters followed by an end marker with status. A steady stream of ordinary characters
// moves at one character per cycle while the result side keeps up. The separator that closes
// the host sends two backslashes, then the host characters before the first '@', one stored
// character per cycle from the host memory's single read port while the result side keeps up,
// then a closing backslash. The last character is followed by the end marker, with a default
// file backslash going out first when the path ended in the share without an error. No new
// character is taken while the result register holds a result that the consumer has not yet taken.
module unc_path_splitter
    import ups_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_ch,
    input  logic              s_final_char,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_part,
    output logic [CHAR_W-1:0] m_out_char,
    output logic [1:0]        m_status,
    output logic              m_run_end
);

    cmd_t cmd;
    sts_t sts;

    ups_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_final_char (s_final_char),
        .s_ready      (s_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    ups_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_ch       (s_ch),
        .cmd        (cmd),
        .sts        (sts),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_part     (m_part),
        .m_out_char (m_out_char),
        .m_status   (m_status),
        .m_run_end  (m_run_end)
    );

endmodule

### rtl/ups_ram.sv
// generic single write port ram with registered read
module ups_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ups_datapath.sv
// path splitter datapath: host store, counters, flags and result register
module ups_datapath
    import ups_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CHAR_W-1:0] s_ch,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_part,
    output logic [CHAR_W-1:0] m_out_char,
    output logic [1:0]        m_status,
    output logic              m_run_end
);

    logic [HOST_CW-1:0] host_count_reg, host_count_next;
    logic [HOST_CW-1:0] prefix_len_reg, prefix_len_next;
    logic [HOST_CW-1:0] rd_idx_reg, rd_idx_next;
    logic               at_seen_reg, at_seen_next;
    logic               fls_reg, fls_next;
    stat_t              err_reg, err_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_part_reg;
    logic [CHAR_W-1:0]  m_char_reg;
    logic [1:0]         m_status_reg;
    logic               m_run_end_reg;
    logic [CHAR_W-1:0]  ram_rdata;
    logic [CHAR_W-1:0]  emit_char;

    ups_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (HOST_MAX)
    ) u_host_ram (
        .aclk  (aclk),
        .we    (cmd.host_wr),
        .waddr (host_count_reg[HOST_AW-1:0]),
        .wdata (s_ch),
        .raddr (rd_idx_next[HOST_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        host_count_next = host_count_reg;
        prefix_len_next = prefix_len_reg;
        at_seen_next    = at_seen_reg;
        fls_next        = fls_reg;
        err_next        = err_reg;
        rd_idx_next     = rd_idx_reg;
        if (cmd.host_wr) begin
            host_count_next = host_count_reg + HOST_CW'(1);
            if (s_ch == CH_AT) begin
                at_seen_next = 1'b1;
            end else if (!at_seen_reg) begin
                prefix_len_next = prefix_len_reg + HOST_CW'(1);
            end
        end
        if (cmd.set_err) begin
            err_next = cmd.err_code;
        end
        if (cmd.set_fls) begin
            fls_next = 1'b1;
        end else if (cmd.clr_fls) begin
            fls_next = 1'b0;
        end
        if (cmd.rd_clr) begin
            rd_idx_next = '0;
        end else if (cmd.rd_inc) begin
            rd_idx_next = rd_idx_reg + HOST_CW'(1);
        end
        if (cmd.clr_all) begin
            host_count_next = '0;
            prefix_len_next = '0;
            at_seen_next    = 1'b0;
            fls_next        = 1'b0;
            err_next        = STAT_OK;
            rd_idx_next     = '0;
        end
    end

    always_comb begin
        unique case (cmd.src)
            SRC_NONE: emit_char = '0;
            SRC_CH:   emit_char = s_ch;
            SRC_BSL:  emit_char = CH_BSL;
            SRC_RAM:  emit_char = ram_rdata;
            default:  emit_char = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_count_reg <= '0;
            prefix_len_reg <= '0;
            at_seen_reg    <= 1'b0;
            fls_reg        <= 1'b0;
            err_reg        <= STAT_OK;
            rd_idx_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            host_count_reg <= host_count_next;
            prefix_len_reg <= prefix_len_next;
            at_seen_reg    <= at_seen_next;
            fls_reg        <= fls_next;
            err_reg        <= err_next;
            rd_idx_reg     <= rd_idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_part_reg    <= cmd.part;
            m_char_reg    <= emit_char;
            m_status_reg  <= cmd.status;
            m_run_end_reg <= cmd.run_end;
        end
    end

    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.is_sep    = (s_ch == CH_BSL) || (s_ch == CH_SLASH);
    assign sts.host_full = (host_count_reg == HOST_CW'(HOST_MAX));
    assign sts.pfx_done  = (rd_idx_reg == prefix_len_reg);
    assign sts.fls       = fls_reg;
    assign sts.err       = err_reg;

    assign m_valid    = m_valid_reg;
    assign m_part     = m_part_reg;
    assign m_out_char = m_char_reg;
    assign m_status   = m_status_reg;
    assign m_run_end  = m_run_end_reg;

endmodule

### rtl/ups_ctrl.sv
// path splitter controller: parse phase and result sequencing state machine
module ups_ctrl
    import ups_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_final_char,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctl_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       last_reg, last_next;
    logic       accept;
    logic       need_def;
    stat_t      end_stat;

    assign s_ready  = (state_reg == CS_IDLE) && sts.out_free;
    assign accept   = s_valid && s_ready;
    assign need_def = (sts.err == STAT_OK) && (phase_reg == PH_SHARE);

    always_comb begin
        if (sts.err != STAT_OK) begin
            end_stat = sts.err;
        end else if ((phase_reg == PH_SHARE) || (phase_reg == PH_FILE)) begin
            end_stat = STAT_OK;
        end else begin
            end_stat = STAT_NO_SHARE;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        last_next  = last_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (accept) begin
                    last_next = s_final_char;
                    unique case (phase_reg)
                        PH_START: phase_next = sts.is_sep ? PH_LEAD : PH_SINK;
                        PH_LEAD: begin
                            if (!sts.is_sep) begin
                                phase_next = sts.host_full ? PH_SINK : PH_HOST;
                            end
                        end
                        PH_HOST: begin
                            if (sts.is_sep) begin
                                phase_next = PH_SHARE;
                            end else if (sts.host_full) begin
                                phase_next = PH_SINK;
                            end
                        end
                        PH_SHARE: begin
                            if (sts.is_sep) begin
                                phase_next = PH_FILE;
                            end
                        end
                        PH_FILE, PH_SINK: phase_next = phase_reg;
                        default: phase_next = phase_reg;
                    endcase
                    if ((phase_reg == PH_HOST) && sts.is_sep) begin
                        state_next = CS_PFX2;
                    end else if (s_final_char) begin
                        state_next = CS_TAIL;
                    end
                end
            end
            CS_PFX2: begin
                if (sts.out_free) begin
                    state_next = CS_PFX_RD;
                end
            end
            CS_PFX_RD: begin
                if (sts.out_free && sts.pfx_done) begin
                    state_next = last_reg ? CS_TAIL : CS_IDLE;
                end
            end
            CS_TAIL: begin
                if (sts.out_free) begin
                    if (need_def) begin
                        state_next = CS_END;
                    end else begin
                        state_next = CS_IDLE;
                        phase_next = PH_START;
                    end
                end
            end
            CS_END: begin
                if (sts.out_free) begin
                    state_next = CS_IDLE;
                    phase_next = PH_START;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            CS_IDLE: begin
                if (accept) begin
                    cmd.run_end = !s_final_char;
                    unique case (phase_reg)
                        PH_START: begin
                            if (!sts.is_sep) begin
                                cmd.set_err  = 1'b1;
                                cmd.err_code = STAT_NO_LEAD;
                            end
                        end
                        PH_LEAD, PH_HOST: begin
                            if ((phase_reg == PH_HOST) && sts.is_sep) begin
                                cmd.emit    = 1'b1;
                                cmd.part    = PART_SHARE;
                                cmd.src     = SRC_BSL;
                                cmd.run_end = 1'b0;
                                cmd.rd_clr  = 1'b1;
                            end else if (!sts.is_sep) begin
                                if (sts.host_full) begin
                                    cmd.set_err  = 1'b1;
                                    cmd.err_code = STAT_HOST_LONG;
                                end else begin
                                    cmd.host_wr = 1'b1;
                                    cmd.emit    = 1'b1;
                                    cmd.part    = PART_HOST;
                                    cmd.src     = SRC_CH;
                                end
                            end
                        end
                        PH_SHARE: begin
                            cmd.emit = 1'b1;
                            if (sts.is_sep) begin
                                cmd.part    = PART_FILE;
                                cmd.src     = SRC_BSL;
                                cmd.set_fls = 1'b1;
                            end else begin
                                cmd.part = PART_SHARE;
                                cmd.src  = SRC_CH;
                            end
                        end
                        PH_FILE: begin
                            if (sts.is_sep) begin
                                cmd.emit    = !sts.fls;
                                cmd.part    = PART_FILE;
                                cmd.src     = SRC_BSL;
                                cmd.set_fls = 1'b1;
                            end else begin
                                cmd.emit    = 1'b1;
                                cmd.part    = PART_FILE;
                                cmd.src     = SRC_CH;
                                cmd.clr_fls = 1'b1;
                            end
                        end
                        PH_SINK: cmd.emit = 1'b0;
                        default: cmd.emit = 1'b0;
                    endcase
                end
            end
            CS_PFX2: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.part = PART_SHARE;
                    cmd.src  = SRC_BSL;
                end
            end
            CS_PFX_RD: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.part = PART_SHARE;
                    if (sts.pfx_done) begin
                        cmd.src     = SRC_BSL;
                        cmd.run_end = !last_reg;
                    end else begin
                        cmd.src    = SRC_RAM;
                        cmd.rd_inc = 1'b1;
                    end
                end
            end
            CS_TAIL, CS_END: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if ((state_reg == CS_TAIL) && need_def) begin
                        cmd.part = PART_FILE;
                        cmd.src  = SRC_BSL;
                    end else begin
                        cmd.part    = PART_END;
                        cmd.src     = SRC_NONE;
                        cmd.status  = end_stat;
                        cmd.run_end = 1'b1;
                        cmd.clr_all = 1'b1;
                    end
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            phase_reg <= PH_START;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
        end
    end

endmodule

### rtl/ups_checker.sv
// port level checks for the path splitter and their binding to the top level
module ups_port_checks
    import ups_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [CHAR_W-1:0] s_ch,
    input logic              s_final_char,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_part,
    input logic [CHAR_W-1:0] m_out_char,
    input logic [1:0]        m_status,
    input logic              m_run_end
);

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_part) && $stable(m_out_char)
            && $stable(m_status) && $stable(m_run_end))
        else $error("result changed while stalled");

    a_end_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_part == PART_END) |-> m_run_end && (m_out_char == '0))
        else $error("end marker without run end or with a character");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_part != PART_END) |-> (m_status == STAT_OK))
        else $error("status on a non end result");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result pending");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind unc_path_splitter ups_port_checks u_ups_port_checks (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_ch         (s_ch),
    .s_final_char (s_final_char),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_part       (m_part),
    .m_out_char   (m_out_char),
    .m_status     (m_status),
    .m_run_end    (m_run_end)
);
